// File: rtl/core/tbo_pkg.sv
`default_nettype none

package tbo_pkg;

   // Field widths of the request and response transfers
   localparam int CMD_W      = 3;
   localparam int ID_W       = 8;
   localparam int DUR_W      = 32;
   localparam int RID_W      = 7;
   localparam int FIRED_W    = 8;
   localparam int KIND_W     = 2;

   // tdata packing: timer_id, timer_mode, duration from bit 0 up
   localparam int ID_LSB     = 0;
   localparam int MODE_LSB   = ID_LSB + ID_W;
   localparam int DUR_LSB    = MODE_LSB + 1;
   localparam int REQ_DATA_W = ((DUR_LSB + DUR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RID_W + FIRED_W + 7) / 8) * 8;

   // Slot kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_FREE     = 2'd0,
      KIND_INTERVAL = 2'd1,
      KIND_ONESHOT  = 2'd2
   } kind_type;

   // Command codes carried in tuser
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 3'd0,
      CMD_CREATE  = 3'd1,
      CMD_START   = 3'd2,
      CMD_RESTART = 3'd3,
      CMD_STOP    = 3'd4,
      CMD_RESUME  = 3'd5,
      CMD_DELETE  = 3'd6
   } cmd_type;

   // Write enables towards the slot count store
   typedef struct packed {
      logic reload_we;
      logic remain_we;
   } wr_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/tbo_alu.sv
`default_nettype none

// Shared decrement and zero-detect unit, used for the tick, start and restart count updates
module tbo_alu #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic [COUNT_WIDTH-1:0] operand,
   input  wire logic                   dec,
   output logic      [COUNT_WIDTH-1:0] diff,
   output logic                        zero
);

   assign diff = operand - COUNT_WIDTH'(dec);
   assign zero = (diff == '0);

endmodule

`default_nettype wire

// File: rtl/core/tbo_slot_mem.sv
`default_nettype none

// Reload and remaining counts per slot: a single address shared by write and read,
// registered read data
module tbo_slot_mem #(
   parameter int TIMER_COUNT = 8,
   parameter int COUNT_WIDTH = 32,
   parameter int IDX_W       = 3
) (
   input  wire logic                    clock,
   input  wire tbo_pkg::wr_ctl_type     wr_ctl,
   input  wire logic [IDX_W-1:0]        addr,
   input  wire logic [COUNT_WIDTH-1:0]  reload_wdata,
   input  wire logic [COUNT_WIDTH-1:0]  remain_wdata,
   output logic      [COUNT_WIDTH-1:0]  reload_rdata,
   output logic      [COUNT_WIDTH-1:0]  remain_rdata
);

   import tbo_pkg::*;

   logic [COUNT_WIDTH-1:0] reload_ff [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] remain_ff [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] reload_rd_ff;
   logic [COUNT_WIDTH-1:0] remain_rd_ff;

   // Writes
   always_ff @(posedge clock) begin
      if (wr_ctl.reload_we) begin
         reload_ff[addr] <= reload_wdata;
      end
      if (wr_ctl.remain_we) begin
         remain_ff[addr] <= remain_wdata;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      reload_rd_ff <= reload_ff[addr];
      remain_rd_ff <= remain_ff[addr];
   end

   assign reload_rdata = reload_rd_ff;
   assign remain_rdata = remain_rd_ff;

endmodule

`default_nettype wire

// File: rtl/core/timer_bank_oneshot_interval.sv
`default_nettype none

// Bank of TIMER_COUNT software timers, interval or one-shot, driven by tick
// and management commands (command code in req_tuser). One command is worked
// on at a time and req_tready is low meanwhile; a finished response sits in
// an output register, so the next command can be taken while it waits. A
// tick visits every slot in turn through the single port of the count store
// and the shared decrement unit: a stopped slot passes through the read state
// only, a running slot through the read and the write state. Create searches
// down from the highest slot, one slot a cycle; restart passes through an
// extra write state that start, stop, resume and delete do not need. No
// clearing pass is needed after reset.
module timer_bank_oneshot_interval #(
   parameter int TIMER_COUNT = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [7:0] timer_id, [8] timer_mode, [40:9] duration, rest zero
   input  wire logic [tbo_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] command
   input  wire logic [tbo_pkg::CMD_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [6:0] result_id, [14:7] fired_mask, [15] zero
   output logic      [tbo_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import tbo_pkg::*;

   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_APPLY,
      S_RESTART_WR,
      S_TICK_RD,
      S_TICK_WR,
      S_CREATE,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic                   mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] dur_ff, dur_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [RID_W-1:0]       rid_ff, rid_in;
   logic [FIRED_W-1:0]     fired_ff, fired_in;
   kind_type               kind_ff [TIMER_COUNT];
   kind_type               kind_in [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] running_ff, running_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   in_range;
   logic [IDX_W-1:0]       slot_idx;
   logic                   id_ok;
   logic                   last_idx;

   wr_ctl_type             wr_ctl;
   logic [COUNT_WIDTH-1:0] reload_wdata;
   logic [COUNT_WIDTH-1:0] remain_wdata;
   logic [COUNT_WIDTH-1:0] reload_rd;
   logic [COUNT_WIDTH-1:0] remain_rd;

   logic [COUNT_WIDTH-1:0] alu_op;
   logic                   alu_dec;
   logic [COUNT_WIDTH-1:0] alu_diff;
   logic                   alu_zero;

   logic                   req_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Id check against the slot table
   assign in_range = (id_ff != '0) && ({1'b0, id_ff} <= (ID_W+1)'(TIMER_COUNT));
   assign slot_idx = IDX_W'(id_ff - ID_W'(1));
   assign id_ok    = in_range && (kind_ff[slot_idx] != KIND_FREE);
   assign last_idx = (idx_ff == IDX_W'(TIMER_COUNT - 1));

   tbo_alu #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_alu (
      .operand (alu_op),
      .dec     (alu_dec),
      .diff    (alu_diff),
      .zero    (alu_zero)
   );

   tbo_slot_mem #(
      .TIMER_COUNT(TIMER_COUNT),
      .COUNT_WIDTH(COUNT_WIDTH),
      .IDX_W      (IDX_W)
   ) u_slot_mem (
      .clock        (clock),
      .wr_ctl       (wr_ctl),
      .addr         (idx_ff),
      .reload_wdata (reload_wdata),
      .remain_wdata (remain_wdata),
      .reload_rdata (reload_rd),
      .remain_rdata (remain_rd)
   );

   // Sequencer next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      mode_in      = mode_ff;
      dur_in       = dur_ff;
      idx_in       = idx_ff;
      rid_in       = rid_ff;
      fired_in     = fired_ff;
      kind_in      = kind_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_ctl       = '{reload_we: 1'b0, remain_we: 1'b0};
      reload_wdata = '0;
      remain_wdata = alu_diff;
      alu_op       = remain_rd;
      alu_dec      = 1'b0;

      // response register drains independently
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = cmd_type'(req_tuser);
               id_in    = req_tdata[ID_LSB +: ID_W];
               mode_in  = req_tdata[MODE_LSB];
               dur_in   = req_tdata[DUR_LSB +: COUNT_WIDTH];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rid_in   = '0;
            fired_in = '0;
            case (cmd_ff)
               CMD_TICK: begin
                  idx_in   = '0;
                  state_in = S_TICK_RD;
               end
               CMD_CREATE: begin
                  idx_in   = IDX_W'(TIMER_COUNT - 1);
                  state_in = S_CREATE;
               end
               CMD_START, CMD_RESTART, CMD_STOP, CMD_RESUME, CMD_DELETE: begin
                  if (id_ok) begin
                     idx_in   = slot_idx;
                     rid_in   = RID_W'(id_ff);
                     state_in = S_APPLY;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_APPLY: begin
            state_in = S_DONE;
            case (cmd_ff)
               CMD_START: begin
                  alu_op             = dur_ff;
                  wr_ctl             = '{reload_we: 1'b1, remain_we: 1'b1};
                  reload_wdata       = dur_ff;
                  remain_wdata       = dur_ff;
                  running_in[idx_ff] = !alu_zero;
               end
               CMD_RESTART: begin
                  // count store read is under way for this slot
                  state_in = S_RESTART_WR;
               end
               CMD_STOP: begin
                  running_in[idx_ff] = 1'b0;
               end
               CMD_RESUME: begin
                  running_in[idx_ff] = 1'b1;
               end
               CMD_DELETE: begin
                  wr_ctl             = '{reload_we: 1'b1, remain_we: 1'b1};
                  remain_wdata       = '0;
                  kind_in[idx_ff]    = KIND_FREE;
                  running_in[idx_ff] = 1'b0;
               end
               default: begin
               end
            endcase
         end
         S_RESTART_WR: begin
            alu_op             = reload_rd;
            wr_ctl             = '{reload_we: 1'b0, remain_we: 1'b1};
            remain_wdata       = reload_rd;
            running_in[idx_ff] = !alu_zero;
            state_in           = S_DONE;
         end
         S_TICK_RD: begin
            if (running_ff[idx_ff]) begin
               state_in = S_TICK_WR;
            end else if (last_idx) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_TICK_WR: begin
            alu_op  = remain_rd;
            alu_dec = 1'b1;
            wr_ctl  = '{reload_we: 1'b0, remain_we: 1'b1};
            if (alu_zero) begin
               fired_in = fired_ff | (FIRED_W'(1) << idx_ff);
               if (kind_ff[idx_ff] == KIND_INTERVAL) begin
                  remain_wdata = reload_rd;
               end else begin
                  running_in[idx_ff] = 1'b0;
               end
            end
            if (last_idx) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_TICK_RD;
            end
         end
         S_CREATE: begin
            if (kind_ff[idx_ff] == KIND_FREE) begin
               kind_in[idx_ff]    = mode_ff ? KIND_ONESHOT : KIND_INTERVAL;
               running_in[idx_ff] = 1'b0;
               wr_ctl             = '{reload_we: 1'b1, remain_we: 1'b1};
               remain_wdata       = '0;
               rid_in             = RID_W'(idx_ff) + RID_W'(1);
               state_in           = S_DONE;
            end else if (idx_ff == '0) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({fired_ff, rid_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < TIMER_COUNT; k++) begin
            kind_ff[k] <= KIND_FREE;
         end
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      mode_ff     <= mode_in;
      dur_ff      <= dur_in;
      idx_ff      <= idx_in;
      rid_ff      <= rid_in;
      fired_ff    <= fired_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Allocation view for checks
   logic [TIMER_COUNT-1:0] alloc_vec;
   always_comb begin
      for (int k = 0; k < TIMER_COUNT; k++) begin
         alloc_vec[k] = (kind_ff[k] != KIND_FREE);
      end
   end

   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after a request transfer");

   a_run_alloc : assert property (@(posedge clock) disable iff (reset)
      (running_ff & ~alloc_vec) == '0)
      else $error("free slot marked running");

   a_rid_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[RID_W-1:0] <= RID_W'(TIMER_COUNT)))
      else $error("result id beyond slot count");

   a_rid_fired_excl : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[RID_W-1:0] != '0))
         |-> (rsp_data_ff[RID_W +: FIRED_W] == '0))
      else $error("fired mask set on a management response");

endmodule

`default_nettype wire

// File: tb/sv/timer_bank_oneshot_interval_test.sv
`default_nettype none

module timer_bank_oneshot_interval_test;
   import tbo_pkg::*;

   localparam int TIMER_COUNT = 8;
   localparam int COUNT_WIDTH = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PERCENT = 24;
   // command 7 has no meaning and must leave the bank untouched
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   // one response transfer as the bank should produce it
   typedef struct packed {
      logic [RID_W-1:0]   result_id;
      logic [FIRED_W-1:0] fired_mask;
   } timer_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the slot state
   kind_type               slot_kind      [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] slot_reload    [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] slot_remaining [TIMER_COUNT];
   logic                   slot_running   [TIMER_COUNT];

   timer_reply_type pending_replies[$];
   timer_reply_type oldest_reply;
   int              error_count = 0;
   int              cycle_count = 0;
   bit              idling_on = 1'b1;

   timer_bank_oneshot_interval #(
      .TIMER_COUNT(TIMER_COUNT),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      if (idling_on)
         rsp_tready = ($urandom_range(99) >= IDLE_PERCENT);
      else
         rsp_tready = 1'b1;
   end

   // compare every response transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $error("response with nothing outstanding: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            oldest_reply = pending_replies.pop_front();
            if (rsp_tdata[RID_W-1:0] !== oldest_reply.result_id) begin
               $error("result_id: expected %0d, got %0d",
                      oldest_reply.result_id, rsp_tdata[RID_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[RID_W +: FIRED_W] !== oldest_reply.fired_mask) begin
               $error("fired_mask: expected %h, got %h",
                      oldest_reply.fired_mask, rsp_tdata[RID_W +: FIRED_W]);
               error_count++;
            end
         end
      end
   end

   function automatic bit slot_in_use(logic [ID_W-1:0] id);
      return (id >= 1) && (id <= TIMER_COUNT) && (slot_kind[id-1] != KIND_FREE);
   endfunction

   // advance the shadow bank by one command and return its response
   function automatic timer_reply_type apply_timer_command(logic [CMD_W-1:0] cmd,
                                                           logic [ID_W-1:0] id,
                                                           logic mode,
                                                           logic [DUR_W-1:0] dur);
      timer_reply_type        reply;
      logic [COUNT_WIDTH-1:0] ticks;
      int                     s;
      int                     k;
      reply = '0;
      ticks = dur[COUNT_WIDTH-1:0];
      k = int'(id) - 1;
      case (cmd)
         CMD_TICK: begin
            // sweep from the top slot down
            for (s = TIMER_COUNT - 1; s >= 0; s--) begin
               if (slot_running[s]) begin
                  slot_remaining[s] = slot_remaining[s] - 1'b1;
                  if (slot_remaining[s] == '0) begin
                     if (s < FIRED_W)
                        reply.fired_mask[s] = 1'b1;
                     if (slot_kind[s] == KIND_INTERVAL)
                        slot_remaining[s] = slot_reload[s];
                     else if (slot_kind[s] == KIND_ONESHOT)
                        slot_running[s] = 1'b0;
                  end
               end
            end
         end
         CMD_CREATE: begin
            for (s = TIMER_COUNT - 1; s >= 0; s--) begin
               if (slot_kind[s] == KIND_FREE) begin
                  slot_kind[s]      = mode ? KIND_ONESHOT : KIND_INTERVAL;
                  slot_reload[s]    = '0;
                  slot_remaining[s] = '0;
                  slot_running[s]   = 1'b0;
                  reply.result_id   = RID_W'(s + 1);
                  break;
               end
            end
         end
         CMD_START: if (slot_in_use(id)) begin
            slot_reload[k]    = ticks;
            slot_remaining[k] = ticks;
            slot_running[k]   = (ticks != '0);
            reply.result_id   = id[RID_W-1:0];
         end
         CMD_RESTART: if (slot_in_use(id)) begin
            slot_remaining[k] = slot_reload[k];
            slot_running[k]   = (slot_reload[k] != '0);
            reply.result_id   = id[RID_W-1:0];
         end
         CMD_STOP: if (slot_in_use(id)) begin
            slot_running[k] = 1'b0;
            reply.result_id = id[RID_W-1:0];
         end
         CMD_RESUME: if (slot_in_use(id)) begin
            slot_running[k] = 1'b1;
            reply.result_id = id[RID_W-1:0];
         end
         CMD_DELETE: if (slot_in_use(id)) begin
            slot_kind[k]      = KIND_FREE;
            slot_reload[k]    = '0;
            slot_remaining[k] = '0;
            slot_running[k]   = 1'b0;
            reply.result_id   = id[RID_W-1:0];
         end
         default: ;
      endcase
      return reply;
   endfunction

   // one request transfer; tvalid stays high afterwards until the next call
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic mode, logic [DUR_W-1:0] dur);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = '0;
      req_tdata[ID_LSB +: ID_W]   = id;
      req_tdata[MODE_LSB]         = mode;
      req_tdata[DUR_LSB +: DUR_W] = dur;
      req_tuser  = cmd;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_replies.push_back(apply_timer_command(cmd, id, mode, dur));
   endtask

   // drop tvalid and hold off until every response is back
   task automatic wait_for_replies();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_command();
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  id;
      logic [DUR_W-1:0] dur;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 35)      cmd = CMD_TICK;
      else if (pick < 45) cmd = CMD_CREATE;
      else if (pick < 60) cmd = CMD_START;
      else if (pick < 68) cmd = CMD_RESTART;
      else if (pick < 76) cmd = CMD_STOP;
      else if (pick < 84) cmd = CMD_RESUME;
      else if (pick < 97) cmd = CMD_DELETE;
      else                cmd = CMD_UNUSED;
      // mostly slots that exist, now and then any id at all
      if ($urandom_range(99) < 85)
         id = ID_W'($urandom_range(1, TIMER_COUNT));
      else
         id = ID_W'($urandom_range(0, 255));
      // short durations so that slots actually expire
      pick = $urandom_range(99);
      if (pick < 80)      dur = DUR_W'($urandom_range(1, 6));
      else if (pick < 90) dur = '0;
      else                dur = $urandom;
      send_command(cmd, id, 1'($urandom_range(0, 1)), dur);
   endtask

   // slot life cycle: expiry of both kinds, zero durations, wrap on resume
   task automatic test_slot_lifecycle();
      send_command(CMD_TICK,    8'd0,   1'b0, '0);
      send_command(CMD_START,   8'd1,   1'b0, 32'd5);
      send_command(CMD_CREATE,  8'd0,   1'b0, '0);
      send_command(CMD_CREATE,  8'd0,   1'b1, '0);
      send_command(CMD_START,   8'd8,   1'b0, 32'd2);
      send_command(CMD_START,   8'd7,   1'b0, 32'd1);
      send_command(CMD_TICK,    8'd0,   1'b0, '0);
      send_command(CMD_TICK,    8'd0,   1'b0, '0);
      send_command(CMD_RESTART, 8'd7,   1'b0, '0);
      send_command(CMD_STOP,    8'd8,   1'b0, '0);
      send_command(CMD_TICK,    8'd0,   1'b0, '0);
      send_command(CMD_RESUME,  8'd8,   1'b0, '0);
      send_command(CMD_START,   8'd7,   1'b0, '0);
      send_command(CMD_RESTART, 8'd7,   1'b0, '0);
      // expired one-shot resumed with nothing left: next tick wraps
      send_command(CMD_RESUME,  8'd7,   1'b0, '0);
      send_command(CMD_TICK,    8'd0,   1'b0, '0);
      send_command(CMD_START,   8'd8,   1'b1, 32'hFFFF_FFFF);
      send_command(CMD_DELETE,  8'd7,   1'b0, '0);
      send_command(CMD_DELETE,  8'd7,   1'b0, '0);
      // ids outside the bank, then the unused command code
      send_command(CMD_STOP,    8'd0,   1'b0, '0);
      send_command(CMD_RESUME,  8'd9,   1'b0, '0);
      send_command(CMD_RESTART, 8'hFF,  1'b1, 32'hFFFF_FFFF);
      send_command(CMD_UNUSED,  8'd8,   1'b1, 32'hFFFF_FFFF);
   endtask

   // fill the bank, one create too many, then empty it again
   task automatic test_bank_full();
      int s;
      for (s = 0; s < TIMER_COUNT; s++)
         send_command(CMD_CREATE, 8'd0, 1'(s % 2), '0);
      for (s = 1; s <= TIMER_COUNT; s++)
         send_command(CMD_DELETE, ID_W'(s), 1'b0, '0);
   endtask

   task automatic test_random_traffic(int item_total);
      repeat (item_total)
         send_random_command();
   endtask

   // both sides flat out
   task automatic test_no_idling(int item_total);
      idling_on = 1'b0;
      repeat (item_total)
         send_random_command();
      idling_on = 1'b1;
   endtask

   // sender holds back until the bank has answered everything
   task automatic test_drain_pause();
      wait_for_replies();
      repeat (10)
         send_random_command();
   endtask

   task automatic finish_run();
      wait_for_replies();
      repeat (2 * TIMER_COUNT + 10)
         @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   endtask

   initial begin
      int s;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      for (s = 0; s < TIMER_COUNT; s++) begin
         slot_kind[s]      = KIND_FREE;
         slot_reload[s]    = '0;
         slot_remaining[s] = '0;
         slot_running[s]   = 1'b0;
      end
      repeat (5)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_slot_lifecycle();
      test_bank_full();
      test_random_traffic(220);
      test_no_idling(60);
      test_drain_pause();
      test_random_traffic(210);
      finish_run();
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/tbo_pkg.sv
rtl/core/tbo_alu.sv
rtl/core/tbo_slot_mem.sv
rtl/core/timer_bank_oneshot_interval.sv
tb/sv/timer_bank_oneshot_interval_test.sv
